/* sv/ert_pkg.sv */
`default_nettype none

package ert_pkg;

    // Table geometry
    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int SLOT_OUT_W = 4;

    // Field widths
    localparam int SEQ_W     = 16;
    localparam int IP_W      = 32;
    localparam int TIME_W    = 32;
    localparam int TMO_W     = 16;
    localparam int MAXS_W    = 5;
    localparam int EV_W      = 3;
    localparam int CMD_W     = 2;

    // Configuration port
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int REG_IDX_LSB = 2;

    localparam logic REG_MAX_SLOTS = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    localparam logic [MAXS_W-1:0] MAX_SLOTS_RST = MAXS_W'(16);
    localparam logic [TMO_W-1:0]  TIMEOUT_RST   = TMO_W'(1000);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SEND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPLY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // Event codes
    localparam logic [EV_W-1:0] EV_SENT      = 3'd0;
    localparam logic [EV_W-1:0] EV_REFUSED   = 3'd1;
    localparam logic [EV_W-1:0] EV_MATCHED   = 3'd2;
    localparam logic [EV_W-1:0] EV_UNMATCHED = 3'd3;
    localparam logic [EV_W-1:0] EV_TIMEOUT   = 3'd4;

    localparam logic [SEQ_W-1:0]  SEQ_NONE = '1;
    localparam logic [TIME_W-1:0] RTT_NONE = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND_MOD,
        ST_SEND_SCAN,
        ST_REPLY_SCAN,
        ST_TICK_SCAN,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [IP_W-1:0]   peer;
        logic [TIME_W-1:0] sent_at;
    } slot_entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_entry_t       data;
    } slot_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } slot_clr_t;

    typedef struct packed {
        logic [EV_W-1:0]       event_res;
        logic [SEQ_W-1:0]      seq_number;
        logic [SLOT_OUT_W-1:0] slot;
        logic [IP_W-1:0]       peer_ip;
        logic [TIME_W-1:0]     round_trip;
    } result_t;

endpackage

`default_nettype wire

/* sv/ert_req_if.sv */
`default_nettype none

interface ert_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] dest_ip;
    logic [15:0] reply_seqno;

    modport source (output valid, command, dest_ip, reply_seqno, input ready);
    modport sink   (input valid, command, dest_ip, reply_seqno, output ready);
endinterface

`default_nettype wire

/* sv/ert_rsp_if.sv */
`default_nettype none

interface ert_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [15:0] seq_number;
    logic [3:0]  slot;
    logic [31:0] peer_ip;
    logic [31:0] round_trip;
    logic        last;

    modport source (output valid, event_res, seq_number, slot, peer_ip, round_trip,
                    last, input ready);
    modport sink   (input valid, event_res, seq_number, slot, peer_ip, round_trip,
                    last, output ready);
endinterface

`default_nettype wire

/* sv/ert_slot_table.sv */
`default_nettype none

module ert_slot_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ert_pkg::slot_wr_t                wr,
    input  ert_pkg::slot_clr_t               clr,
    input  logic [ert_pkg::SLOT_W-1:0]       rd_addr,
    output ert_pkg::slot_entry_t             rd_data,
    output logic [ert_pkg::MAX_SLOTS-1:0]    valid
);
    import ert_pkg::*;

    slot_entry_t           mem [MAX_SLOTS];
    slot_entry_t           rd_data_reg;
    logic [MAX_SLOTS-1:0]  valid_reg;
    logic [MAX_SLOTS-1:0]  valid_next;

    // Entry store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Live flags: set on a send, cleared on match or expiry
    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
        if (clr.en)
        begin
            valid_next[clr.addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

`default_nettype wire

/* sv/ert_age_unit.sv */
`default_nettype none

module ert_age_unit (
    input  logic [ert_pkg::TIME_W-1:0] now_ticks,
    input  logic [ert_pkg::TIME_W-1:0] sent_at,
    input  logic [ert_pkg::TMO_W-1:0]  timeout_ticks,
    output logic [ert_pkg::TIME_W-1:0] elapsed,
    output logic                       expired
);
    import ert_pkg::*;

    // Age modulo 2^32, compared against the timeout
    assign elapsed = now_ticks - sent_at;
    assign expired = (elapsed >= TIME_W'(timeout_ticks));

endmodule

`default_nettype wire

/* sv/ert_sequencer.sv */
`default_nettype none

module ert_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    ert_req_if.sink                        req,
    ert_rsp_if.source                      rsp,
    input  logic [ert_pkg::MAXS_W-1:0]     max_slots,
    input  logic [ert_pkg::TMO_W-1:0]      timeout_ticks,
    output ert_pkg::slot_wr_t              wr,
    output ert_pkg::slot_clr_t             clr,
    output logic [ert_pkg::SLOT_W-1:0]     rd_addr,
    input  ert_pkg::slot_entry_t           rd_data,
    input  logic [ert_pkg::MAX_SLOTS-1:0]  valid
);
    import ert_pkg::*;

    localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(MAX_SLOTS - 1);

    seq_state_t           state_reg, state_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]     steps_reg, steps_next;
    logic [CNT_W-1:0]     mod_reg, mod_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [SEQ_W-1:0]     last_seq_reg, last_seq_next;
    logic [SLOT_W-1:0]    last_slot_reg, last_slot_next;
    logic                 held_valid_reg, held_valid_next;
    result_t              held_reg, held_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;
    logic                 out_last_reg, out_last_next;
    logic [IP_W-1:0]      dest_reg;
    logic [SEQ_W-1:0]     rseq_reg;

    logic [CNT_W-1:0]     cnt;
    logic                 accept;
    logic                 out_free;
    logic [TIME_W-1:0]    elapsed;
    logic                 expired;
    logic                 hit;
    logic [SEQ_W-1:0]     new_seq;

    // Shared age subtractor
    ert_age_unit u_age (
        .now_ticks     (now_reg),
        .sent_at       (rd_data.sent_at),
        .timeout_ticks (timeout_ticks),
        .elapsed       (elapsed),
        .expired       (expired)
    );

    // Slots in use, clamped to 1..MAX_SLOTS
    always_comb
    begin
        if (max_slots == '0)
        begin
            cnt = CNT_W'(1);
        end
        else if (32'(max_slots) > 32'(MAX_SLOTS))
        begin
            cnt = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            cnt = CNT_W'(max_slots);
        end
    end

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign hit      = valid[idx_reg] && expired;
    assign new_seq  = last_seq_reg + SEQ_W'(1);

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        steps_next      = steps_reg;
        mod_next        = mod_reg;
        now_next        = now_reg;
        last_seq_next   = last_seq_reg;
        last_slot_next  = last_slot_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        wr              = '0;
        clr.en          = 1'b0;
        clr.addr        = idx_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    case (req.command)
                        CMD_SEND:
                        begin
                            mod_next   = CNT_W'(last_slot_reg) + CNT_W'(1);
                            state_next = ST_SEND_MOD;
                        end
                        CMD_REPLY:
                        begin
                            state_next = ST_REPLY_SCAN;
                        end
                        CMD_TICK:
                        begin
                            now_next   = now_reg + TIME_W'(1);
                            state_next = ST_TICK_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // First candidate: (last_slot + 1) mod cnt by repeated subtraction
            ST_SEND_MOD:
            begin
                if (mod_reg >= cnt)
                begin
                    mod_next = mod_reg - cnt;
                end
                else
                begin
                    idx_next   = mod_reg[SLOT_W-1:0];
                    steps_next = cnt;
                    state_next = ST_SEND_SCAN;
                end
            end

            // Round-robin search for a free slot
            ST_SEND_SCAN:
            begin
                if (!valid[idx_reg])
                begin
                    wr.en                = 1'b1;
                    wr.addr              = idx_reg;
                    wr.data.seq          = new_seq;
                    wr.data.peer         = dest_reg;
                    wr.data.sent_at      = now_reg;
                    last_slot_next       = idx_reg;
                    last_seq_next        = new_seq;
                    held_valid_next      = 1'b1;
                    held_next.event_res  = EV_SENT;
                    held_next.seq_number = new_seq;
                    held_next.slot       = SLOT_OUT_W'(idx_reg);
                    held_next.peer_ip    = dest_reg;
                    held_next.round_trip = '0;
                    state_next           = ST_FINISH;
                end
                else if (steps_reg == CNT_W'(1))
                begin
                    held_valid_next      = 1'b1;
                    held_next.event_res  = EV_REFUSED;
                    held_next.seq_number = SEQ_NONE;
                    held_next.slot       = '0;
                    held_next.peer_ip    = '0;
                    held_next.round_trip = '0;
                    state_next           = ST_FINISH;
                end
                else
                begin
                    steps_next = steps_reg - CNT_W'(1);
                    if (CNT_W'(idx_reg) + CNT_W'(1) == cnt)
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end

            // Lowest live slot holding the reply's number
            ST_REPLY_SCAN:
            begin
                if (valid[idx_reg] && (rd_data.seq == rseq_reg))
                begin
                    clr.en               = 1'b1;
                    held_valid_next      = 1'b1;
                    held_next.event_res  = EV_MATCHED;
                    held_next.seq_number = rseq_reg;
                    held_next.slot       = SLOT_OUT_W'(idx_reg);
                    held_next.peer_ip    = rd_data.peer;
                    held_next.round_trip = elapsed;
                    state_next           = ST_FINISH;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    held_valid_next      = 1'b1;
                    held_next.event_res  = EV_UNMATCHED;
                    held_next.seq_number = rseq_reg;
                    held_next.slot       = '0;
                    held_next.peer_ip    = '0;
                    held_next.round_trip = '0;
                    state_next           = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            // Expiry sweep; a found expiry pushes the previous one out
            ST_TICK_SCAN:
            begin
                if (!(hit && held_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = held_reg;
                            out_last_next  = 1'b0;
                        end
                        clr.en               = 1'b1;
                        held_valid_next      = 1'b1;
                        held_next.event_res  = EV_TIMEOUT;
                        held_next.seq_number = rd_data.seq;
                        held_next.slot       = SLOT_OUT_W'(idx_reg);
                        held_next.peer_ip    = rd_data.peer;
                        held_next.round_trip = RTT_NONE;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end

            // Final transaction of the item carries last
            ST_FINISH:
            begin
                if (!held_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = held_reg;
                    out_last_next   = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read address runs one step ahead of the index
    assign rd_addr = idx_next;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            steps_reg      <= '0;
            mod_reg        <= '0;
            now_reg        <= '0;
            last_seq_reg   <= '0;
            last_slot_reg  <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            steps_reg      <= steps_next;
            mod_reg        <= mod_next;
            now_reg        <= now_next;
            last_seq_reg   <= last_seq_next;
            last_slot_reg  <= last_slot_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        held_reg     <= held_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (accept)
        begin
            dest_reg <= req.dest_ip;
            rseq_reg <= req.reply_seqno;
        end
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.event_res  = out_reg.event_res;
    assign rsp.seq_number = out_reg.seq_number;
    assign rsp.slot       = out_reg.slot;
    assign rsp.peer_ip    = out_reg.peer_ip;
    assign rsp.round_trip = out_reg.round_trip;
    assign rsp.last       = out_last_reg;

endmodule

`default_nettype wire

/* sv/echo_request_tracker.sv */
// Echo request tracker: keeps up to 16 outstanding echo requests with a
// 16-bit wrapping sequence number, peer address and send time each. A send
// first finds its start position, (last_slot + 1) mod slots-in-use, by
// repeated subtraction, then probes slots round-robin from there, at most
// the slots in use. A reply visits slots in ascending order up to and
// including the match, all 16 when unmatched. A tick visits every slot once
// through the table's single registered read port and the shared age
// subtractor. Tick results for several expiries leave one per transaction in
// ascending slot order, the final one marked with last; a stalled result
// port holds the sweep and the final transaction. No item is accepted while
// one is in work. There is no clearing pass after reset. Configuration
// (max_slots at 0x0, timeout_ticks at 0x4) is to be written by the user
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module echo_request_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    ert_req_if.sink                        req,
    ert_rsp_if.source                      rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ert_pkg::ADDR_W-1:0]     paddr,
    input  logic [ert_pkg::DATA_W-1:0]     pwdata,
    output logic [ert_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import ert_pkg::*;

    logic [MAXS_W-1:0]     max_slots_reg;
    logic [TMO_W-1:0]      timeout_reg;
    logic                  cfg_wr;
    logic                  reg_sel;
    slot_wr_t              wr;
    slot_clr_t             clr;
    logic [SLOT_W-1:0]     rd_addr;
    slot_entry_t           rd_data;
    logic [MAX_SLOTS-1:0]  valid;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[REG_IDX_LSB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_slots_reg <= MAX_SLOTS_RST;
            timeout_reg   <= TIMEOUT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_MAX_SLOTS: max_slots_reg <= pwdata[MAXS_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= pwdata[TMO_W-1:0];
                default:       max_slots_reg <= max_slots_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (reg_sel)
            REG_MAX_SLOTS: prdata = DATA_W'(max_slots_reg);
            REG_TIMEOUT:   prdata = DATA_W'(timeout_reg);
            default:       prdata = '0;
        endcase
    end

    ert_sequencer u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .max_slots     (max_slots_reg),
        .timeout_ticks (timeout_reg),
        .wr            (wr),
        .clr           (clr),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .valid         (valid)
    );

    ert_slot_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .clr     (clr),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .valid   (valid)
    );

endmodule

`default_nettype wire
